@@ rtl/core/wpm_pkg.sv @@
// ----------------------------------------------------------------------------
// wpm_pkg: shared types and constants for the wildcard pattern matcher
// Command codes of the request channel and the two wildcard characters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wpm_pkg;

   typedef logic [1:0] cmd_type;
   typedef logic [7:0] sym_type;

   localparam cmd_type CMD_CLEAR  = 2'd0;
   localparam cmd_type CMD_APPEND = 2'd1;
   localparam cmd_type CMD_TEXT   = 2'd2;
   localparam cmd_type CMD_END    = 2'd3;

   localparam sym_type SYM_STAR = 8'h2A;   // '*'
   localparam sym_type SYM_ANY  = 8'h3F;   // '?'

endpackage

`default_nettype wire

@@ rtl/core/wildcard_pattern_matcher.sv @@
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher
// Whole-string glob matcher ('*' any run, '?' any byte) over a loaded pattern.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries a command and a byte. Clear empties the pattern,
//   append adds one pattern byte (dropped and flagged when full), text feeds
//   one text byte, end-of-text produces one rsp item (matched and
//   pattern_overflow) and rearms matching for the next text. Only end-of-text
//   items produce a response.
//   Flow: an item is registered in the input register on acceptance and
//   processed from there; a response is registered in the result register.
//   One item is taken every cycle while no end-of-text item waits for rsp:
//   each text byte updates all pattern positions at once, and the star
//   closure is a log-depth prefix scan. When rsp stalls, items that give no
//   response keep flowing; an end-of-text item waits in the input register
//   until the pending response is taken, and req_ready drops meanwhile.
//   Reset: pattern empty, overflow flag clear, only position zero active,
//   no item in flight. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wildcard_pattern_matcher
   import wpm_pkg::*;
#(
   parameter int MAX_PATTERN = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire cmd_type req_command,
   input  wire sym_type req_symbol,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output logic         rsp_matched,
   output logic         rsp_pattern_overflow
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int LVLS  = $clog2(MAX_PATTERN + 1);

   // input register
   logic    stg_valid_ff, stg_valid_in;
   cmd_type stg_cmd_ff;
   sym_type stg_sym_ff;

   // matcher state
   sym_type          pat_ff [MAX_PATTERN];
   logic [LEN_W-1:0] len_ff, len_in;
   logic [MAX_PATTERN:0] act_ff, act_in;
   logic             ovf_ff, ovf_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic matched_ff, matched_in;
   logic rsp_ovf_ff, rsp_ovf_in;

   logic stg_go;
   logic pat_full;
   logic do_append;
   logic [MAX_PATTERN-1:0] in_pat;
   logic [MAX_PATTERN-1:0] star;
   logic [MAX_PATTERN-1:0] hit;
   logic [MAX_PATTERN:0]   cur;
   logic [MAX_PATTERN:0]   nxt;

   // an end item may only move on when the result register is free or its response is being taken
   assign stg_go    = !(stg_valid_ff && (stg_cmd_ff == CMD_END)
                        && rsp_valid_ff && !rsp_ready);
   assign req_ready = !stg_valid_ff || stg_go;
   assign pat_full  = (len_ff == LEN_W'(MAX_PATTERN));
   assign do_append = stg_valid_ff && stg_go && (stg_cmd_ff == CMD_APPEND)
                      && !pat_full;

   always_comb begin
      for (int p = 0; p < MAX_PATTERN; p++) begin
         in_pat[p] = (LEN_W'(p) < len_ff);
         star[p]   = in_pat[p] && (pat_ff[p] == SYM_STAR);
         hit[p]    = (pat_ff[p] == SYM_ANY) || (pat_ff[p] == stg_sym_ff);
      end
   end

   // star closure: c[p] = act[p] | (star[p-1] & c[p-1]), as a prefix scan
   always_comb begin
      logic [MAX_PATTERN:0] g, a, g_prv, a_prv;
      g = act_ff;
      a = '0;
      for (int p = 1; p <= MAX_PATTERN; p++) begin
         a[p] = star[p-1];
      end
      for (int l = 0; l < LVLS; l++) begin
         g_prv = g;
         a_prv = a;
         for (int p = 0; p <= MAX_PATTERN; p++) begin
            if (p >= (1 << l)) begin
               g[p] = g_prv[p] | (a_prv[p] & g_prv[p - (1 << l)]);
               a[p] = a_prv[p] & a_prv[p - (1 << l)];
            end
         end
      end
      cur = g;
   end

   always_comb begin
      nxt = '0;
      for (int p = 0; p < MAX_PATTERN; p++) begin
         if (cur[p] && in_pat[p]) begin
            if (star[p]) begin
               nxt[p] = 1'b1;
            end else if (hit[p]) begin
               nxt[p+1] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      stg_valid_in = stg_valid_ff;
      len_in       = len_ff;
      act_in       = act_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      matched_in   = matched_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (req_ready) begin
         stg_valid_in = req_valid;
      end

      if (stg_valid_ff && stg_go) begin
         unique case (stg_cmd_ff)
            CMD_CLEAR: begin
               len_in = '0;
               ovf_in = 1'b0;
               act_in = (MAX_PATTERN + 1)'(1);
            end
            CMD_APPEND: begin
               if (pat_full) begin
                  ovf_in = 1'b1;
               end else begin
                  len_in = len_ff + LEN_W'(1);
               end
               act_in = (MAX_PATTERN + 1)'(1);
            end
            CMD_TEXT: begin
               act_in = nxt;
            end
            CMD_END: begin
               rsp_valid_in = 1'b1;
               matched_in   = cur[len_ff];
               rsp_ovf_in   = ovf_ff;
               act_in       = (MAX_PATTERN + 1)'(1);
            end
            default: begin
               act_in = act_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         len_ff       <= '0;
         act_ff       <= (MAX_PATTERN + 1)'(1);
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         len_ff       <= len_in;
         act_ff       <= act_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         stg_cmd_ff <= req_command;
         stg_sym_ff <= req_symbol;
      end
      matched_ff <= matched_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   // pattern store: written at the current length, read at every position
   always_ff @(posedge clock) begin
      for (int p = 0; p < MAX_PATTERN; p++) begin
         if (do_append && (len_ff == LEN_W'(p))) begin
            pat_ff[p] <= stg_sym_ff;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = matched_ff;
   assign rsp_pattern_overflow = rsp_ovf_ff;

endmodule

`default_nettype wire
